// ----- hdl/cgt_pkg.sv -----
// Shared types and constants of the chordal graph tester.
`timescale 1ns / 1ps
package cgt_pkg;

    // Fixed field widths of the request and count register
    localparam int CMD_W   = 2;
    localparam int VTX_W   = 6;
    localparam int COUNT_W = 7;

    // Command codes carried by a request item
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST     = 2'd2;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_RD_A,
        S_EDGE_WR_A,
        S_EDGE_WR_B,
        S_V_SCAN,
        S_V_LOAD,
        S_U_SCAN,
        S_U_CHECK,
        S_RES_YES,
        S_RES_NO
    } state_t;

    // Row memory read address source
    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_V,
        RD_U
    } rd_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    item_take;
        logic    clear_rows;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_a;
        logic    wr_b;
        logic    live_init;
        logic    v_clr;
        logic    v_inc;
        logic    u_clr;
        logic    u_inc;
        logic    nbrs_load;
        logic    live_drop;
        logic    out_set;
        logic    out_chordal;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic edge_ok;
        logic n_zero;
        logic v_end;
        logic v_live;
        logic u_end;
        logic u_nbr;
        logic simp_fail;
        logic live_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- hdl/cgt_req_if.sv -----
// Request channel: command and edge endpoints with valid/ready handshake.
`timescale 1ns / 1ps
interface cgt_req_if import cgt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;

    modport source (output valid, output cmd, output vertex_a, output vertex_b, input ready);
    modport sink   (input valid, input cmd, input vertex_a, input vertex_b, output ready);
endinterface

// ----- hdl/cgt_rsp_if.sv -----
// Response channel: chordality verdict with valid/ready handshake.
`timescale 1ns / 1ps
interface cgt_rsp_if;
    logic valid;
    logic ready;
    logic chordal;

    modport source (output valid, output chordal, input ready);
    modport sink   (input valid, input chordal, output ready);
endinterface

// ----- hdl/chordal_graph_test.sv -----
// Top level of the chordal graph tester.
//
// Loads an undirected graph one edge item at a time into a row memory of
// MAX_VERTICES rows and tests it for chordality by simplicial elimination.
// An add-edge item is accepted, then updates both endpoint rows by two
// read-modify-writes over one memory write port (read A, write A while
// reading B, write B); it is dropped at acceptance when it is a self-loop or
// an endpoint is out of range. A clear needs no clearing pass, since per-row
// valid bits drop every row at once; cmd 3 is dropped. A test runs the
// elimination loop over the single row read port: it skips vertices no longer
// live, the probe of a live vertex v checks its live neighbours (a neighbour
// that fails ends the probe early), and a pass restarts from vertex 0 after
// every removal.
// New items are taken only between items; a finished verdict waits in an
// output register, so edge items can be loaded while it is still unread.
`timescale 1ns / 1ps
module chordal_graph_test
    import cgt_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    cgt_req_if.sink            request,
    cgt_rsp_if.source          response
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequence loading and testing
    cgt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_cmd   (request.cmd),
        .req_ready (request.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the graph and run the elimination
    cgt_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .vertex_a    (request.vertex_a),
        .vertex_b    (request.vertex_b),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (response.ready),
        .out_valid   (response.valid),
        .out_chordal (response.chordal)
    );

endmodule

// ----- hdl/cgt_ctrl.sv -----
// Controller state machine for edge loading and simplicial elimination.
`timescale 1ns / 1ps
module cgt_ctrl
    import cgt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [CMD_W-1:0] req_cmd,
    output logic             req_ready,
    input  dp_status_t       status,
    output dp_cmd_t          cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold the current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence the datapath
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_A;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.item_take = 1'b1;
                    unique case (req_cmd)
                        CMD_ADD_EDGE:
                        begin
                            if (status.edge_ok)
                            begin
                                state_next = S_EDGE_RD_A;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cmd.clear_rows = 1'b1;
                        end
                        CMD_TEST:
                        begin
                            cmd.live_init = 1'b1;
                            cmd.v_clr     = 1'b1;
                            state_next    = status.n_zero ? S_RES_YES : S_V_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EDGE_RD_A:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_A;
                state_next = S_EDGE_WR_A;
            end
            S_EDGE_WR_A:
            begin
                cmd.wr_a   = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_B;
                state_next = S_EDGE_WR_B;
            end
            S_EDGE_WR_B:
            begin
                cmd.wr_b   = 1'b1;
                state_next = S_IDLE;
            end
            S_V_SCAN:
            begin
                priority if (status.v_end)
                begin
                    state_next = S_RES_NO;
                end
                else if (status.v_live)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_V;
                    state_next = S_V_LOAD;
                end
                else
                begin
                    cmd.v_inc = 1'b1;
                end
            end
            S_V_LOAD:
            begin
                cmd.nbrs_load = 1'b1;
                cmd.u_clr     = 1'b1;
                state_next    = S_U_SCAN;
            end
            S_U_SCAN:
            begin
                priority if (status.u_end)
                begin
                    // Vertex is simplicial: drop it and restart the pass
                    cmd.live_drop = 1'b1;
                    cmd.v_clr     = 1'b1;
                    state_next    = status.live_last ? S_RES_YES : S_V_SCAN;
                end
                else if (status.u_nbr)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_U;
                    state_next = S_U_CHECK;
                end
                else
                begin
                    cmd.u_inc = 1'b1;
                end
            end
            S_U_CHECK:
            begin
                if (status.simp_fail)
                begin
                    cmd.v_inc  = 1'b1;
                    state_next = S_V_SCAN;
                end
                else
                begin
                    cmd.u_inc  = 1'b1;
                    state_next = S_U_SCAN;
                end
            end
            S_RES_YES:
            begin
                if (status.out_free)
                begin
                    cmd.out_set     = 1'b1;
                    cmd.out_chordal = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_RES_NO:
            begin
                if (status.out_free)
                begin
                    cmd.out_set = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/cgt_datapath.sv -----
// Datapath: adjacency row memory, live and neighbour masks, counters, result register.
`timescale 1ns / 1ps
module cgt_datapath
    import cgt_pkg::*;
#(
    parameter int MAX_VERTICES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [COUNT_W-1:0] cfg_wr_data,
    input  logic [VTX_W-1:0]   vertex_a,
    input  logic [VTX_W-1:0]   vertex_b,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               out_chordal
);

    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [COUNT_W-1:0]      vertex_count_reg;
    logic [CNT_W-1:0]        n_eff;
    logic [COUNT_W-1:0]      n_ext;

    logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic [MAX_VERTICES-1:0] rd_data_reg;
    logic                    rd_valid_reg;
    logic [MAX_VERTICES-1:0] row_eff;
    logic [IDX_W-1:0]        rd_addr;
    logic [IDX_W-1:0]        wr_addr;
    logic [MAX_VERTICES-1:0] wr_data;
    logic                    wr_en;

    logic [IDX_W-1:0]        a_reg;
    logic [IDX_W-1:0]        b_reg;
    logic [CNT_W-1:0]        v_reg;
    logic [CNT_W-1:0]        u_reg;
    logic [IDX_W-1:0]        v_idx;
    logic [IDX_W-1:0]        u_idx;
    logic [MAX_VERTICES-1:0] live_reg;
    logic [MAX_VERTICES-1:0] live_init;
    logic [MAX_VERTICES-1:0] nbrs_reg;
    logic [MAX_VERTICES-1:0] v_bit;
    logic [MAX_VERTICES-1:0] u_bit;
    logic [MAX_VERTICES-1:0] a_bit;
    logic [MAX_VERTICES-1:0] b_bit;

    logic                    out_valid_reg;
    logic                    out_chordal_reg;

    // Clamp the vertex count to the matrix size
    always_comb
    begin
        if (vertex_count_reg > COUNT_W'(MAX_VERTICES))
        begin
            n_eff = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_eff = vertex_count_reg[CNT_W-1:0];
        end
        n_ext = COUNT_W'(n_eff);
    end

    // Build the starting live set: every vertex below the count
    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            live_init[i] = (CNT_W'(i) < n_eff);
        end
    end

    assign v_idx = v_reg[IDX_W-1:0];
    assign u_idx = u_reg[IDX_W-1:0];
    assign v_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << v_idx;
    assign u_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << u_idx;
    assign a_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_reg;
    assign b_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << b_reg;

    // A row never written since the last clear reads as empty
    assign row_eff = rd_valid_reg ? rd_data_reg : '0;

    // Select the row memory read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_A:    rd_addr = a_reg;
            RD_B:    rd_addr = b_reg;
            RD_V:    rd_addr = v_idx;
            RD_U:    rd_addr = u_idx;
            default: rd_addr = a_reg;
        endcase
    end

    // Merge the new edge bit into the row just read
    assign wr_en   = cmd.wr_a | cmd.wr_b;
    assign wr_addr = cmd.wr_a ? a_reg : b_reg;
    assign wr_data = row_eff | (cmd.wr_a ? b_bit : a_bit);

    // Row memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track written rows; a clear drops them all at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear_rows)
            begin
                row_valid_reg <= '0;
            end
            else if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // Latch the edge endpoints of an accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.item_take)
        begin
            a_reg <= vertex_a[IDX_W-1:0];
            b_reg <= vertex_b[IDX_W-1:0];
        end
    end

    // Count register, live set, neighbour set and scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
            live_reg         <= '0;
            nbrs_reg         <= '0;
            v_reg            <= '0;
            u_reg            <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vertex_count_reg <= cfg_wr_data;
            end
            if (cmd.live_init)
            begin
                live_reg <= live_init;
            end
            else if (cmd.live_drop)
            begin
                live_reg <= live_reg & ~v_bit;
            end
            if (cmd.nbrs_load)
            begin
                nbrs_reg <= row_eff & live_reg;
            end
            if (cmd.v_clr)
            begin
                v_reg <= '0;
            end
            else if (cmd.v_inc)
            begin
                v_reg <= v_reg + CNT_W'(1);
            end
            if (cmd.u_clr)
            begin
                u_reg <= '0;
            end
            else if (cmd.u_inc)
            begin
                u_reg <= u_reg + CNT_W'(1);
            end
        end
    end

    // Result register: hold the verdict until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            out_chordal_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_set)
            begin
                out_valid_reg   <= 1'b1;
                out_chordal_reg <= cmd.out_chordal;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_chordal = out_chordal_reg;

    // Report status to the controller
    always_comb
    begin
        status.edge_ok   = ({1'b0, vertex_a} < n_ext) && ({1'b0, vertex_b} < n_ext)
                           && (vertex_a != vertex_b);
        status.n_zero    = (n_eff == '0);
        status.v_end     = (v_reg == n_eff);
        status.v_live    = live_reg[v_idx];
        status.u_end     = (u_reg == n_eff);
        status.u_nbr     = nbrs_reg[u_idx];
        status.simp_fail = ((nbrs_reg & ~u_bit & ~row_eff) != '0);
        status.live_last = ((live_reg & ~v_bit) == '0);
        status.out_free  = !out_valid_reg || out_ready;
    end

endmodule
